[src/utf16_to_utf8_transcoder_defines.svh]
// assertion macros used by the checker file
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// property checked at every clock edge outside reset
`define UTT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every clock edge, reset included
`define UTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/utt_pkg.sv]
// shared types and constants of the utf-16 to utf-8 transcoder
package utt_pkg;

    localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_END    = 16'hE000;
    localparam logic [20:0] PAIR_BASE       = 21'h10000;
    localparam logic [20:0] CP_MAX_1BYTE    = 21'h0007F;
    localparam logic [20:0] CP_MAX_2BYTE    = 21'h007FF;
    localparam logic [20:0] CP_MAX_3BYTE    = 21'h0FFFF;
    localparam logic [1:0]  CONT_TAG        = 2'b10;

    // one encode request from the front part to the back part
    typedef struct packed {
        logic        pre_valid;
        logic [9:0]  pre_bits;
        logic        main_valid;
        logic [20:0] main_cp;
        logic        eos;
    } t_job;

endpackage

[src/utt_ifs.sv]
// valid/ready channel interfaces for code units and utf-8 bytes
interface utt_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_string;

    modport source (output valid, output code_unit, output end_of_string, input ready);
    modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface utt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;

    modport source (output valid, output out_byte, output run_last, output string_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_last,
                    output ready);
endinterface

[src/utt_front.sv]
// front part: accepts code units, pairs surrogates and builds encode requests
module utt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utt_unit_if.sink      i_unit,
    output utt_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import utt_pkg::*;

    logic        r_held_valid;
    logic [9:0]  r_held_bits;
    logic        n_held_valid;
    logic [9:0]  n_held_bits;
    logic        w_accept;
    logic        w_is_high;
    logic        w_is_low;
    logic        w_pair;
    logic        w_hold;
    t_job        w_job;

    assign w_is_high = (i_unit.code_unit >= SURR_HIGH_FIRST)
                    && (i_unit.code_unit < SURR_LOW_FIRST);
    assign w_is_low  = (i_unit.code_unit >= SURR_LOW_FIRST)
                    && (i_unit.code_unit < SURR_LOW_END);
    assign w_pair    = r_held_valid && w_is_low;
    assign w_hold    = w_is_high && !i_unit.end_of_string;

    assign i_unit.ready = i_job_ready;
    assign w_accept     = i_unit.valid && i_unit.ready;

    always_comb begin
        w_job     = '0;
        w_job.eos = i_unit.end_of_string;
        if (w_pair) begin
            w_job.main_valid = 1'b1;
            w_job.main_cp    = PAIR_BASE + 21'({r_held_bits, i_unit.code_unit[9:0]});
        end else begin
            w_job.pre_valid  = r_held_valid;
            w_job.pre_bits   = r_held_bits;
            w_job.main_valid = !w_hold;
            w_job.main_cp    = 21'(i_unit.code_unit);
        end
    end

    assign o_job       = w_job;
    assign o_job_valid = i_unit.valid && (w_pair || r_held_valid || !w_hold);

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        if (w_accept) begin
            if (w_pair || !w_hold) begin
                n_held_valid = 1'b0;
                n_held_bits  = '0;
            end else begin
                n_held_valid = 1'b1;
                n_held_bits  = i_unit.code_unit[9:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
        end
    end

endmodule

[src/utt_queue.sv]
// short request queue between the front and back parts
module utt_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  utt_pkg::t_job i_push_data,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    output utt_pkg::t_job o_pop_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready
);
    import utt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_head];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (w_pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

[src/utt_back.sv]
// back part: walks each request and sends utf-8 bytes through an output register
module utt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  utt_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    utt_byte_if.source    o_byte
);
    import utt_pkg::*;

    typedef enum logic {
        PH_PRE,
        PH_MAIN
    } t_phase;

    t_phase      r_phase;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_run_last;
    logic        r_string_last;
    logic        w_use_pre;
    logic [20:0] w_cp;
    logic [1:0]  w_len_m1;
    logic [7:0]  w_byte;
    logic        w_last_byte;
    logic        w_run_last;
    logic        w_load;
    logic        w_advance;

    function automatic logic [1:0] f_len_m1(input logic [20:0] cp);
        logic [1:0] len;
        if (cp <= CP_MAX_1BYTE) begin
            len = 2'd0;
        end else if (cp <= CP_MAX_2BYTE) begin
            len = 2'd1;
        end else if (cp <= CP_MAX_3BYTE) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

    function automatic logic [7:0] f_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                          input logic [1:0] idx);
        logic [7:0] b;
        b = '0;
        unique case (len_m1)
            2'd0: b = cp[7:0];
            2'd1: begin
                b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {CONT_TAG, cp[5:0]};
            end
            2'd2: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {CONT_TAG, cp[11:6]};
                    default: b = {CONT_TAG, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {CONT_TAG, cp[17:12]};
                    2'd2:    b = {CONT_TAG, cp[11:6]};
                    default: b = {CONT_TAG, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    // held lone surrogate goes first, then the unit itself
    assign w_use_pre   = i_job.pre_valid && (r_phase == PH_PRE);
    assign w_cp        = w_use_pre ? {5'b00000, 6'b110110, i_job.pre_bits} : i_job.main_cp;
    assign w_len_m1    = f_len_m1(w_cp);
    assign w_byte      = f_byte(w_cp, w_len_m1, r_idx);
    assign w_last_byte = (r_idx == w_len_m1);
    assign w_run_last  = w_last_byte && !(w_use_pre && i_job.main_valid);

    assign w_load      = !r_out_valid || o_byte.ready;
    assign w_advance   = i_job_valid && w_load;
    assign o_job_ready = w_advance && w_run_last;

    assign o_byte.valid       = r_out_valid;
    assign o_byte.out_byte    = r_out_byte;
    assign o_byte.run_last    = r_run_last;
    assign o_byte.string_last = r_string_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PRE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= i_job_valid;
            end
            if (w_advance) begin
                if (!w_last_byte) begin
                    r_idx <= r_idx + 1'b1;
                end else if (w_run_last) begin
                    r_idx   <= '0;
                    r_phase <= PH_PRE;
                end else begin
                    r_idx   <= '0;
                    r_phase <= PH_MAIN;
                end
            end
        end
        if (w_advance) begin
            r_out_byte    <= w_byte;
            r_run_last    <= w_run_last;
            r_string_last <= w_run_last && i_job.eos;
        end
    end

endmodule

[src/utf16_to_utf8_transcoder.sv]
// utf16_to_utf8_transcoder: top level of the utf-16 to utf-8 transcoder
// Takes one UTF-16 code unit per request and sends UTF-8 bytes, one byte per
// request on the output channel. A front part pairs surrogates and may take a
// code unit every cycle while the request queue (QUEUE_DEPTH entries) has room;
// a back part encodes one byte per cycle while the output is not stalled,
// behind a registered output. A unit yields no bytes for a held high
// surrogate, 1 to 3 for a plain unit, 4 for a surrogate pair, and up to 6 when
// a lone held surrogate is flushed ahead of the next unit; the single byte
// output port sets the sustained rate. A unit's request passes through the
// request queue and then the output register before its first byte shows.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utt_unit_if.sink   i_unit,
    utt_byte_if.source o_byte
);
    import utt_pkg::*;

    t_job w_push_job;
    logic w_push_valid;
    logic w_push_ready;
    t_job w_pop_job;
    logic w_pop_valid;
    logic w_pop_ready;

    utt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_unit      (i_unit),
        .o_job       (w_push_job),
        .o_job_valid (w_push_valid),
        .i_job_ready (w_push_ready)
    );

    utt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_data  (w_push_job),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .o_pop_data   (w_pop_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready)
    );

    utt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_pop_job),
        .i_job_valid (w_pop_valid),
        .o_job_ready (w_pop_ready),
        .o_byte      (o_byte)
    );

endmodule

[src/utt_checker.sv]
// port-level checks on the transcoder output and their binding to the top level
`include "utf16_to_utf8_transcoder_defines.svh"

module utt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_run_last,
    input logic       i_string_last
);

    `UTT_ASSERT(a_string_last_ends_run, i_clk, i_rst_n, i_out_valid && i_string_last |-> i_run_last, "string end not on a run end")
    `UTT_ASSERT(a_lead_not_last, i_clk, i_rst_n, i_out_valid && (i_out_byte[7:6] == 2'b11) |-> !i_run_last, "lead byte closes a run")
    `UTT_ASSERT(a_ascii_ends_run, i_clk, i_rst_n, i_out_valid && !i_out_byte[7] |-> i_run_last, "single byte does not close its run")
    `UTT_ASSERT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_run_last) && $stable(i_string_last), "stalled byte changed")

endmodule

bind utf16_to_utf8_transcoder utt_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_byte.valid),
    .i_out_ready   (o_byte.ready),
    .i_out_byte    (o_byte.out_byte),
    .i_run_last    (o_byte.run_last),
    .i_string_last (o_byte.string_last)
);
